FILE: design/kms_pkg.sv
package kms_pkg;

  localparam int unsigned NUM_LINES   = 8;
  localparam int unsigned LINE_W      = 3;
  localparam int unsigned CODE_W      = 7;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [CODE_W-1:0] KEY_SHIFT_LOCK = 7'd34;
  localparam logic [CODE_W-1:0] KEY_RESTORE    = 7'd31;
  localparam logic [7:0]        ALL_HIGH       = 8'hFF;

  // Right shift, which shift lock keeps held down.
  localparam logic [LINE_W-1:0] RSHIFT_ROW = 3'd6;
  localparam logic [LINE_W-1:0] RSHIFT_COL = 3'd4;
  // Left-shift position that shift lock pulls low.
  localparam logic [LINE_W-1:0] LSHIFT_ROW = 3'd1;
  localparam logic [LINE_W-1:0] LSHIFT_COL = 3'd7;

  typedef enum logic [2:0] {
    FUNC_PRESS       = 3'd0,
    FUNC_RELEASE     = 3'd1,
    FUNC_RELEASE_ALL = 3'd2,
    FUNC_SENSE_COLS  = 3'd3,
    FUNC_SENSE_ROWS  = 3'd4,
    FUNC_QUERY       = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_item;
    logic apply_op;
    logic scan_step;
    logic load_out;
  } kms_cmd_t;

  typedef struct packed {
    logic is_sense;
    logic scan_last;
    logic out_free;
  } kms_status_t;

endpackage

FILE: design/keyboard_matrix_scanner_top.sv
// Press, release, release-all, query: the item is captured, applied in EXEC, and its
// result loaded in DONE; a sense first walks the eight rows one a cycle in SCAN.
// Items are worked one at a time; a new item is taken in the cycle after its result is
// loaded into the output register, which stalls while a held result is not taken.
// Reset (rst, synchronous, active high): all keys released, shift lock and restore clear,
// output empty.
module keyboard_matrix_scanner_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [6:0] key_code, [9:7] key_row, [12:10] key_col, [20:13] drive_mask,
  // [28:21] threshold_mask, [31:29] zero
  input  logic [kms_pkg::IN_TDATA_W-1:0]     s_tdata,
  // [2:0] func
  input  logic [2:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [7:0] port_value, [8] key_down, [9] restore_line, [15:10] zero
  output logic [kms_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import kms_pkg::*;

  kms_cmd_t    cmd;
  kms_status_t status;

  kms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  kms_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

FILE: design/kms_ctrl.sv
module kms_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  kms_pkg::kms_status_t status,
  output kms_pkg::kms_cmd_t    cmd
);
  import kms_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = status.is_sense ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (status.scan_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready      = 1'b1;
        cmd.load_item = s_tvalid;
      end
      ST_EXEC: cmd.apply_op  = 1'b1;
      ST_SCAN: cmd.scan_step = 1'b1;
      ST_DONE: cmd.load_out  = status.out_free;
      default: ;
    endcase
  end

endmodule

FILE: design/kms_datapath.sv
module kms_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [2:0]                          s_tuser,
  input  logic [kms_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [kms_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  kms_pkg::kms_cmd_t                   cmd,
  output kms_pkg::kms_status_t                status
);
  import kms_pkg::*;

  // Captured item.
  func_t              func_q;
  logic [CODE_W-1:0]  code_q;
  logic [LINE_W-1:0]  row_q;
  logic [LINE_W-1:0]  col_q;
  logic [7:0]         drive_q;
  logic [7:0]         thresh_q;

  // Key state; a clear bit is a pressed key.
  logic [7:0]         key_matrix [NUM_LINES];
  logic               shift_lock;
  logic               restore;

  // Scan sequencer and accumulators.
  logic [LINE_W-1:0]  scan_row;
  logic [7:0]         col_acc;
  logic [7:0]         seen_one;
  logic [7:0]         seen_two;

  logic [LINE_W-1:0]  rd_addr;
  logic [7:0]         rd_data;
  logic [7:0]         pressed;
  logic               is_lock;
  logic               is_restore;
  logic               rshift_kept;
  logic [7:0]         port_val;
  logic               down_val;
  logic               out_valid;
  logic [7:0]         out_port;
  logic               out_down;
  logic               out_restore;

  assign rd_addr     = cmd.scan_step ? scan_row : row_q;
  assign rd_data     = key_matrix[rd_addr];
  assign pressed     = ~rd_data;
  assign is_lock     = (code_q == KEY_SHIFT_LOCK);
  assign is_restore  = (code_q == KEY_RESTORE);
  assign rshift_kept = (row_q == RSHIFT_ROW) && (col_q == RSHIFT_COL) && shift_lock;

  assign status.is_sense  = (func_q == FUNC_SENSE_COLS) || (func_q == FUNC_SENSE_ROWS);
  assign status.scan_last = (scan_row == LINE_W'(NUM_LINES - 1));
  assign status.out_free  = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_q   <= func_t'(s_tuser);
      code_q   <= s_tdata[6:0];
      row_q    <= s_tdata[9:7];
      col_q    <= s_tdata[12:10];
      drive_q  <= s_tdata[20:13];
      thresh_q <= s_tdata[28:21];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_LINES; r++) key_matrix[r] <= ALL_HIGH;
      shift_lock <= 1'b0;
      restore    <= 1'b0;
    end else if (cmd.apply_op) begin
      unique case (func_q)
        FUNC_PRESS: begin
          if (is_lock) begin
            shift_lock <= 1'b1;
          end else if (is_restore) begin
            restore <= 1'b1;
          end else begin
            key_matrix[row_q][col_q] <= 1'b0;
          end
        end
        FUNC_RELEASE: begin
          if (is_lock) begin
            shift_lock <= 1'b0;
          end else if (is_restore) begin
            restore <= 1'b0;
          end else if (!rshift_kept) begin
            key_matrix[row_q][col_q] <= 1'b1;
          end
        end
        FUNC_RELEASE_ALL: begin
          for (int r = 0; r < NUM_LINES; r++) key_matrix[r] <= ALL_HIGH;
          restore <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // One matrix row per cycle; each row folds into both sense directions.
  always_ff @(posedge clk) begin
    if (cmd.apply_op) begin
      scan_row <= '0;
      col_acc  <= ALL_HIGH;
      seen_one <= '0;
      seen_two <= '0;
    end else if (cmd.scan_step) begin
      scan_row <= scan_row + 1'b1;
      if ((pressed & drive_q) != 8'h00) col_acc[scan_row] <= 1'b0;
      if (drive_q[scan_row]) begin
        seen_two <= seen_two | (seen_one & pressed);
        seen_one <= seen_one | pressed;
      end
    end
  end

  always_comb begin
    port_val = ALL_HIGH;
    down_val = 1'b0;
    unique case (func_q)
      FUNC_SENSE_COLS: begin
        port_val = col_acc;
        if (shift_lock && drive_q[LSHIFT_COL]) port_val[LSHIFT_ROW] = 1'b0;
      end
      FUNC_SENSE_ROWS: begin
        port_val = ~((thresh_q & seen_two) | (~thresh_q & seen_one));
        if (shift_lock && drive_q[LSHIFT_ROW]) port_val[LSHIFT_COL] = 1'b0;
      end
      FUNC_QUERY: begin
        if (is_lock) begin
          down_val = shift_lock;
        end else if (is_restore) begin
          down_val = restore;
        end else begin
          down_val = !rd_data[col_q];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_port    <= port_val;
      out_down    <= down_val;
      out_restore <= restore;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_restore, out_down, out_port};

endmodule

FILE: design/kms_checker.sv
module kms_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // A held result must not change until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Items are worked one at a time, so no transfer directly follows another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in progress");

  // Only a query reports a held key, and a query never returns sensed lines.
  a_query_port: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'hFF)
    else $error("key_down set alongside a sensed port value");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present after reset");

endmodule

bind keyboard_matrix_scanner_top kms_checker u_kms_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
